/* hw/rtl/ple_pkg.sv */
// shared types and constants for the positional list engine
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 7;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + LENGTH_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

endpackage

/* hw/rtl/ple_cell.sv */
// one list slot: holds an entry and shifts it to or from its neighbors
module ple_cell
    import ple_pkg::*;
(
    input  logic                  aclk,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.take_new) begin
            data_next = new_data;
        end else if (ctl.take_left) begin
            data_next = left_data;
        end else if (ctl.take_right) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hw/rtl/positional_list_engine.sv */
// top level of the positional list engine: command decode, cell row and result register
//
// ordered list of up to CAPACITY entries addressed by 1-based position.
// input words: s_tuser carries the command (insert, remove, read, write,
// clear), s_tdata the position and the entry value. every command yields
// exactly one output word: m_tdata carries the read value and the list
// length after the command, m_tuser the status (ok, bad position, full).
// each slot of the list is a cell of a row; insert and remove move all
// cells from the given position on at once by one place.
// latency: result word is valid the cycle after the command is accepted.
// throughput: one command per cycle while the output is drained.
// the output register frees in the same cycle it is taken, so s_tready
// stays high as long as m_tready is high or no result is held.
// when the receiver stalls, the held result stays and s_tready drops.
// reset (aresetn low, synchronous) empties the list and drops m_tvalid;
// entry contents are not cleared and are unreachable until rewritten.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // position[6:0], entry_value[38:7], zero pad
    input  logic [CMD_W-1:0]     s_tuser,  // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // read_value[31:0], length[38:32], zero pad
    output logic [STATUS_W-1:0]  m_tuser   // status[1:0]
);

    logic                  accept;
    op_t                   cmd;
    logic [POS_W-1:0]      position;
    logic [VALUE_W-1:0]    entry_value;
    logic [DATA_WIDTH-1:0] new_data;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] slot;
    logic             pos_ok;
    logic             ins_pos_ok;
    logic             full;

    logic    do_ins;
    logic    do_rem;
    logic    do_wr;
    logic    do_rd;
    status_t status;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [VALUE_W-1:0]    read_value_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [LENGTH_W-1:0]   length_reg;

    cell_ctl_t             ctl      [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_data[CAPACITY];
    logic [CAPACITY-1:0]   at_slot;
    logic [CAPACITY-1:0]   after_slot;
    logic [DATA_WIDTH-1:0] rd_sel;

    assign s_tready    = !m_tvalid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign cmd         = op_t'(s_tuser);
    assign position    = s_tdata[POS_W-1:0];
    assign entry_value = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign new_data    = DATA_WIDTH'(entry_value);

    assign pos_ext    = CMP_W'(position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign slot       = pos_ext - CMP_W'(1);
    assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign full       = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        do_wr      = 1'b0;
        do_rd      = 1'b0;
        status     = ST_OK;
        count_next = count_reg;
        case (cmd)
            OP_INSERT: begin
                if (!ins_pos_ok) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!pos_ok) begin
                    status = ST_BADPOS;
                end else begin
                    do_rem     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (!pos_ok) begin
                    status = ST_BADPOS;
                end else begin
                    do_rd = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!pos_ok) begin
                    status = ST_BADPOS;
                end else begin
                    do_wr = 1'b1;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // cell row: cell i holds list position i+1
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_in;
            logic [DATA_WIDTH-1:0] right_in;

            assign at_slot[gi]    = (slot == CMP_W'(gi));
            assign after_slot[gi] = (slot < CMP_W'(gi));

            assign ctl[gi].take_new   = accept && (do_ins || do_wr) && at_slot[gi];
            assign ctl[gi].take_left  = accept && do_ins && after_slot[gi];
            assign ctl[gi].take_right = accept && do_rem && (at_slot[gi] || after_slot[gi]);

            if (gi == 0) begin : g_first
                assign left_in = new_data;
            end else begin : g_mid
                assign left_in = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_in = '0;
            end else begin : g_inner
                assign right_in = cell_data[gi+1];
            end

            ple_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl[gi]),
                .new_data   (new_data),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_sel = rd_sel | (at_slot[i] ? cell_data[i] : '0);
        end
    end

    assign read_value_next = do_rd ? VALUE_W'(rd_sel) : '0;
    assign m_tvalid_next   = accept || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_value_reg <= read_value_next;
            status_reg     <= status;
            length_reg     <= LENGTH_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({length_reg, read_value_reg});
    assign m_tuser  = status_reg;

    // list never grows past its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // a successful insert grows the list by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && do_ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    // a clear empties the list
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (cmd == OP_CLEAR) |=> count_reg == '0)
        else $error("clear left entries behind");

    // reported length tracks the list length
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> length_reg == LENGTH_W'(count_reg))
        else $error("reported length differs from list length");

    // at most one cell loads the new entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> $onehot0(at_slot))
        else $error("more than one cell selected");

endmodule

/* test/ple_checker.sv */
// checker for the positional list engine: predicts each result word and compares it
module ple_checker
    import ple_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // position[6:0], entry_value[38:7], zero pad
    input  logic [CMD_W-1:0]     s_tuser,  // cmd[2:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // read_value[31:0], length[38:32], zero pad
    input  logic [STATUS_W-1:0]  m_tuser,  // status[1:0]
    output int                   fail_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        status_t             status;
        logic [LENGTH_W-1:0] length;
    } list_response_t;

    list_response_t        expected_responses[$];
    logic [DATA_WIDTH-1:0] list_entries [CAPACITY];
    int                    list_len;

    task automatic predict_response(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                    input logic [VALUE_W-1:0] value,
                                    output list_response_t resp);
        int p;
        p = int'(pos);
        resp = '0;
        resp.status = ST_OK;
        case (cmd)
            OP_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    resp.status = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    resp.status = ST_FULL;
                end else begin
                    for (int i = list_len; i >= p; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[p-1] = value[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (p < 1 || p > list_len) begin
                    resp.status = ST_BADPOS;
                end else begin
                    for (int i = p; i < list_len; i++)
                        list_entries[i-1] = list_entries[i];
                    list_len--;
                end
            end
            OP_READ: begin
                if (p < 1 || p > list_len)
                    resp.status = ST_BADPOS;
                else
                    resp.read_value = VALUE_W'(list_entries[p-1]);
            end
            OP_WRITE: begin
                if (p < 1 || p > list_len)
                    resp.status = ST_BADPOS;
                else
                    list_entries[p-1] = value[DATA_WIDTH-1:0];
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        resp.length = LENGTH_W'(list_len);
    endtask

    always @(posedge aclk) begin
        list_response_t want;
        list_response_t got;
        if (!aresetn) begin
            list_len = 0;
            expected_responses.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_value = m_tdata[VALUE_W-1:0];
                got.length     = m_tdata[VALUE_W +: LENGTH_W];
                got.status     = status_t'(m_tuser);
                if (expected_responses.size() == 0) begin
                    $error("result word with no command pending");
                    fail_count++;
                end else begin
                    want = expected_responses.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0h, actual %0h",
                               want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tuser);
                        fail_count++;
                    end
                    if (got.length !== want.length) begin
                        $error("length mismatch: expected %0d, actual %0d",
                               want.length, got.length);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_response(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W +: VALUE_W], want);
                expected_responses.push_back(want);
            end
        end
        outstanding = expected_responses.size();
    end

endmodule

/* test/testbench.sv */
// top of the positional list engine testbench: clock, reset, stimulus and verdict
module testbench
    import ple_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // position[6:0], entry_value[38:7], zero pad
    logic [CMD_W-1:0]     s_tuser  = '0;  // cmd[2:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // read_value[31:0], length[38:32], zero pad
    logic [STATUS_W-1:0]  m_tuser;        // status[1:0]

    int fail_count;
    int outstanding;
    int send_idle_pct = 24;
    int recv_idle_pct = 58;
    int stim_len = 0;

    positional_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ple_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input int pos,
                             input logic [VALUE_W-1:0] value);
        int gap;
        bit ready_seen;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({value, pos[POS_W-1:0]});
        s_tuser  <= cmd;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        // track the list length so random positions can stay mostly in range
        case (cmd)
            OP_INSERT: if (pos >= 1 && pos <= stim_len + 1 && stim_len < CAPACITY) stim_len++;
            OP_REMOVE: if (pos >= 1 && pos <= stim_len) stim_len--;
            OP_CLEAR:  stim_len = 0;
            default: ;
        endcase
    endtask

    initial begin
        int send_pcts[3];
        int recv_pcts[3];
        int roll;
        int pos;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        send_pcts = '{24, 58, 0};
        recv_pcts = '{58, 24, 0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, inserts, reads, writes, removes, bad ops, clear
        send_word(OP_READ,   1,  32'h1111_1111);
        send_word(OP_REMOVE, 1,  32'h0);
        send_word(OP_WRITE,  1,  32'hdead_beef);
        send_word(OP_INSERT, 0,  32'h0bad_0000);
        send_word(OP_INSERT, 2,  32'h0bad_0002);
        send_word(OP_INSERT, 1,  32'h0000_0000);
        send_word(OP_INSERT, 2,  32'hffff_ffff);
        send_word(OP_INSERT, 1,  32'ha5a5_a5a5);
        send_word(OP_INSERT, 4,  32'h5a5a_5a5a);
        for (int p = 1; p <= 5; p++)
            send_word(OP_READ, p, 32'h0);
        send_word(OP_WRITE,  2,  32'h1234_5678);
        send_word(OP_READ,   2,  32'h0);
        send_word(OP_REMOVE, 4,  32'h0);
        send_word(OP_REMOVE, 1,  32'h0);
        send_word(OP_READ,   1,  32'h0);
        send_word(OP_READ,   65, 32'h0);
        for (int c = int'(OP_CLEAR) + 1; c < (1 << CMD_W); c++)
            send_word(CMD_W'(c), 1, 32'hffff_ffff);
        send_word(OP_CLEAR,  64, 32'h0);
        send_word(OP_READ,   1,  32'h0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = send_pcts[phase];
            recv_idle_pct = recv_pcts[phase];
            // fill past capacity to exercise shifting at every depth and the full status
            send_word(OP_CLEAR, $urandom_range(65), $urandom);
            for (int k = 0; k < CAPACITY + 2; k++)
                send_word(OP_INSERT, $urandom_range(stim_len + 1, 1), $urandom);
            for (int k = 0; k < 85; k++) begin
                roll = $urandom_range(99);
                if (roll < 42)      cmd = OP_INSERT;
                else if (roll < 62) cmd = OP_REMOVE;
                else if (roll < 80) cmd = OP_READ;
                else if (roll < 96) cmd = OP_WRITE;
                else if (roll < 97) cmd = OP_CLEAR;
                else                cmd = CMD_W'($urandom_range((1 << CMD_W) - 1));
                if ($urandom_range(99) < 85) begin
                    if (cmd == OP_INSERT)
                        pos = $urandom_range(stim_len + 1, 1);
                    else
                        pos = (stim_len == 0) ? 1 : $urandom_range(stim_len, 1);
                end else begin
                    pos = $urandom_range(CAPACITY + 1);
                end
                case ($urandom_range(9))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom;
                endcase
                send_word(cmd, pos, value);
            end
        end
        s_tvalid <= 1'b0;

        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("positional_list_engine regression: pass");
        else
            $display("positional_list_engine regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("positional_list_engine regression: fail");
        $finish;
    end

endmodule
